### hdl/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

   typedef enum logic [1:0] {
      CSR_TEMP_COEFFS  = 2'd0,
      CSR_PRESS_A      = 2'd1,
      CSR_PRESS_B      = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } csr_index_type;

   // quotient bits of the two dividers
   localparam int TQ_BITS = 27;
   localparam int PQ_BITS = 32;

   localparam int B6_OFFSET   = 4000;
   localparam int CORR_SQ     = 3038;
   localparam int CORR_LIN    = -7357;
   localparam int CORR_OFS    = 3791;
   localparam int PRESS_SCALE = 50000;
   localparam int B4_BIAS     = 32768;
   localparam logic [63:0] Q_BOUND = 64'h0000_0000_8000_0000;

endpackage

`default_nettype wire

### hdl/barometric_sensor_compensation.sv
`default_nettype none

// Integer compensation for a barometric pressure sensor: each item carries a raw
// temperature and a raw pressure word and yields temperature in 0.1 degC, pressure
// in Pa (both saturated) and a flag for a zero divisor. Calibration words and the
// oversampling setting sit in four registers written through the csr port; the
// user must write them only while no item is in flight, as the block itself does
// not enforce this. The pipeline takes one item per cycle unless the result side
// stalls, which freezes the whole pipeline; its depth comes mostly from the two
// bit-per-stage dividers (27 stages for the temperature quotient, 32 for pressure).
module barometric_sensor_compensation (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [15:0] raw_temp, [34:16] raw_press, [39:35] zero
   input  wire logic [39:0]                   req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [15:0] temp_tenths, [35:16] press_pa, [39:36] zero
   output logic [39:0]                        rsp_tdata,
   // [0] div_error
   output logic                               rsp_tuser,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire bsc_pkg::csr_index_type        csr_index,
   input  wire logic [63:0]                   csr_wdata
);
   import bsc_pkg::*;

   localparam int TQ    = TQ_BITS;
   localparam int PQ    = PQ_BITS;
   localparam int TDW   = 19 + TQ;
   localparam int PNW   = 74;
   localparam int PDW   = 48 + PQ;
   localparam int P_TD0 = 1;
   localparam int P_T1  = P_TD0 + TQ + 1;
   localparam int P_M5  = P_T1 + 5;
   localparam int P_PD0 = P_T1 + 7;
   localparam int P_F1  = P_PD0 + PQ + 1;
   localparam int P_F3  = P_F1 + 2;
   localparam int P_OUT = P_F3 + 1;

   typedef struct packed {
      logic signed [15:0] t;
      logic               err;
      logic               pz;
      logic [18:0]        up;
   } carry_type;

   // ---------------- configuration
   logic [63:0] temp_coeffs_ff, press_a_ff;
   logic [31:0] press_b_ff;
   logic [1:0]  oss_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         oss_ff         <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_COEFFS:  temp_coeffs_ff <= csr_wdata;
            CSR_PRESS_A:      press_a_ff     <= csr_wdata;
            CSR_PRESS_B:      press_b_ff     <= csr_wdata[31:0];
            CSR_OVERSAMPLING: oss_ff         <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic signed [16:0] ac5, ac6, ac4;
   logic signed [15:0] mc, md, ac1, ac2, ac3, b1, b2;
   assign ac5 = {1'b0, temp_coeffs_ff[63:48]};
   assign ac6 = {1'b0, temp_coeffs_ff[47:32]};
   assign mc  = temp_coeffs_ff[31:16];
   assign md  = temp_coeffs_ff[15:0];
   assign ac1 = press_a_ff[63:48];
   assign ac2 = press_a_ff[47:32];
   assign ac3 = press_a_ff[31:16];
   assign ac4 = {1'b0, press_a_ff[15:0]};
   assign b1  = press_b_ff[31:16];
   assign b2  = press_b_ff[15:0];

   // ---------------- flow control
   logic             en;
   logic [P_OUT:0]   v_ff;

   assign en         = ~v_ff[P_OUT] | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[P_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[P_OUT-1:0], req_tvalid};
      end
   end

   // ---------------- stage 0: (UT - AC6) * AC5
   logic signed [16:0] dut;
   logic signed [33:0] p1_in, p1_ff;
   logic [18:0]        up1_ff;

   assign dut   = $signed({1'b0, req_tdata[15:0]}) - ac6;
   assign p1_in = dut * ac5;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= p1_in;
         up1_ff <= req_tdata[34:16];
      end
   end

   // ---------------- temperature divider, MC*2048 / (X1 + MD)
   logic signed [18:0] x1_in, tdiv_in;
   logic signed [26:0] tnum;

   assign x1_in   = 19'(p1_ff >>> 15);
   assign tdiv_in = x1_in + 19'(md);
   assign tnum    = 27'(mc) <<< 11;

   logic [TQ-1:0]      td_r_ff   [0:TQ];
   logic [TQ-1:0]      td_q_ff   [0:TQ];
   logic [18:0]        td_d_ff   [0:TQ];
   logic               td_neg_ff [0:TQ];
   logic               td_z_ff   [0:TQ];
   logic signed [18:0] td_x1_ff  [0:TQ];
   logic [18:0]        td_up_ff  [0:TQ];

   always_ff @(posedge clock) begin
      if (en) begin
         td_r_ff[0]   <= tnum[26] ? TQ'(-tnum) : TQ'(tnum);
         td_q_ff[0]   <= '0;
         td_d_ff[0]   <= tdiv_in[18] ? 19'(-tdiv_in) : 19'(tdiv_in);
         td_neg_ff[0] <= tnum[26] ^ tdiv_in[18];
         td_z_ff[0]   <= (tdiv_in == '0);
         td_x1_ff[0]  <= x1_in;
         td_up_ff[0]  <= up1_ff;
      end
   end

   for (genvar k = 1; k <= TQ; k++) begin : g_td
      logic [TDW-1:0] cand, rext;
      logic           take;
      assign cand = TDW'(td_d_ff[k-1]) << (TQ - k);
      assign rext = TDW'(td_r_ff[k-1]);
      assign take = rext >= cand;
      always_ff @(posedge clock) begin
         if (en) begin
            td_r_ff[k]   <= take ? TQ'(rext - cand) : td_r_ff[k-1];
            td_q_ff[k]   <= td_q_ff[k-1] | (take ? (TQ'(1) << (TQ - k)) : '0);
            td_d_ff[k]   <= td_d_ff[k-1];
            td_neg_ff[k] <= td_neg_ff[k-1];
            td_z_ff[k]   <= td_z_ff[k-1];
            td_x1_ff[k]  <= td_x1_ff[k-1];
            td_up_ff[k]  <= td_up_ff[k-1];
         end
      end
   end

   // ---------------- B5, temperature result, B6
   logic signed [27:0] x2_in;
   logic signed [28:0] b5_in, b6_in, b6_ff;
   logic signed [24:0] tsh;
   logic signed [15:0] t_in;

   assign x2_in = td_z_ff[TQ]   ? '0 :
                  td_neg_ff[TQ] ? -$signed({1'b0, td_q_ff[TQ]}) : $signed({1'b0, td_q_ff[TQ]});
   assign b5_in = 29'(td_x1_ff[TQ]) + 29'(x2_in);
   assign b6_in = b5_in - 29'(B6_OFFSET);
   assign tsh   = 25'((b5_in + 29'sd8) >>> 4);
   assign t_in  = (tsh > 25'sd32767)  ? 16'sh7FFF :
                  (tsh < -25'sd32768) ? 16'sh8000 : 16'(tsh);

   carry_type car_ff [P_T1:P_F3];

   always_ff @(posedge clock) begin
      if (en) begin
         b6_ff          <= b6_in;
         car_ff[P_T1].t   <= t_in;
         car_ff[P_T1].err <= td_z_ff[TQ];
         car_ff[P_T1].pz  <= 1'b0;
         car_ff[P_T1].up  <= td_up_ff[TQ];
      end
   end

   // pressure-divisor flag joins the carried fields at the divider entry
   logic pz_in;

   for (genvar i = P_T1 + 1; i <= P_F3; i++) begin : g_car
      always_ff @(posedge clock) begin
         if (en) begin
            if (i == P_PD0) begin
               car_ff[i] <= {car_ff[i-1].t, car_ff[i-1].err, pz_in, car_ff[i-1].up};
            end else begin
               car_ff[i] <= car_ff[i-1];
            end
         end
      end
   end

   // ---------------- products on B6
   logic signed [57:0] sq_ff;
   logic signed [44:0] ac2b6_ff, ac3b6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= 58'(b6_ff) * 58'(b6_ff);
         ac2b6_ff <= 45'(ac2) * 45'(b6_ff);
         ac3b6_ff <= 45'(ac3) * 45'(b6_ff);
      end
   end

   logic signed [45:0] bsq;
   logic signed [61:0] mb2_ff, mb1_ff;
   logic signed [33:0] x2a_ff;
   logic signed [31:0] x1c_ff;

   assign bsq = 46'(sq_ff >>> 12);

   always_ff @(posedge clock) begin
      if (en) begin
         mb2_ff <= 62'(b2) * 62'(bsq);
         mb1_ff <= 62'(b1) * 62'(bsq);
         x2a_ff <= 34'(ac2b6_ff >>> 11);
         x1c_ff <= 32'(ac3b6_ff >>> 13);
      end
   end

   logic signed [51:0] x3a_ff;
   logic signed [44:0] x3b_ff;
   logic signed [46:0] x3b_sum;

   assign x3b_sum = 47'(mb1_ff >>> 16) + 47'(x1c_ff) + 47'sd2;

   always_ff @(posedge clock) begin
      if (en) begin
         x3a_ff <= 52'(mb2_ff >>> 11) + 52'(x2a_ff);
         x3b_ff <= 45'(x3b_sum >>> 2);
      end
   end

   // ---------------- B3 and B4 product
   logic signed [56:0] b3_pre;
   logic signed [54:0] b3_ff;
   logic signed [62:0] b4m_ff;

   assign b3_pre = ((((57'(ac1) <<< 2) + 57'(x3a_ff)) <<< oss_ff) + 57'sd2);

   always_ff @(posedge clock) begin
      if (en) begin
         b3_ff  <= 55'(b3_pre >>> 2);
         b4m_ff <= 63'(ac4) * (63'(x3b_ff) + 63'(B4_BIAS));
      end
   end

   logic signed [47:0] b4_ff, b4b_ff;
   logic signed [55:0] diff_ff;
   logic signed [72:0] b7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         b4_ff   <= 48'(b4m_ff >>> 15);
         diff_ff <= $signed({37'b0, car_ff[P_M5-1].up}) - 56'(b3_ff);
         b7_ff   <= 73'(diff_ff) * 73'(17'(PRESS_SCALE >> oss_ff));
         b4b_ff  <= b4_ff;
      end
   end

   // ---------------- pressure divider, B7 / B4
   logic               case_a;
   logic signed [PNW-1:0] pnum;
   logic [PNW-1:0]     pnmag;
   logic [47:0]        pdmag;

   assign case_a = ~b7_ff[72] && (b7_ff < $signed({9'b0, Q_BOUND}));
   assign pnum   = case_a ? (PNW'(b7_ff) <<< 1) : PNW'(b7_ff);
   assign pnmag  = pnum[PNW-1] ? PNW'(-pnum) : PNW'(pnum);
   assign pdmag  = b4b_ff[47] ? 48'(-b4b_ff) : 48'(b4b_ff);
   assign pz_in  = (b4b_ff == '0);

   logic [PNW-1:0] pd_r_ff   [0:PQ];
   logic [PQ-1:0]  pd_q_ff   [0:PQ];
   logic [47:0]    pd_d_ff   [0:PQ];
   logic           pd_neg_ff [0:PQ];
   logic           pd_ovf_ff [0:PQ];
   logic           pd_a_ff   [0:PQ];

   always_ff @(posedge clock) begin
      if (en) begin
         pd_r_ff[0]   <= pnmag;
         pd_q_ff[0]   <= '0;
         pd_d_ff[0]   <= pdmag;
         pd_neg_ff[0] <= pnum[PNW-1] ^ b4b_ff[47];
         pd_ovf_ff[0] <= PDW'(pnmag) >= (PDW'(pdmag) << PQ);
         pd_a_ff[0]   <= case_a;
      end
   end

   for (genvar k = 1; k <= PQ; k++) begin : g_pd
      logic [PDW-1:0] cand, rext;
      logic           take;
      assign cand = PDW'(pd_d_ff[k-1]) << (PQ - k);
      assign rext = PDW'(pd_r_ff[k-1]);
      assign take = rext >= cand;
      always_ff @(posedge clock) begin
         if (en) begin
            pd_r_ff[k]   <= take ? PNW'(rext - cand) : pd_r_ff[k-1];
            pd_q_ff[k]   <= pd_q_ff[k-1] | (take ? (PQ'(1) << (PQ - k)) : '0);
            pd_d_ff[k]   <= pd_d_ff[k-1];
            pd_neg_ff[k] <= pd_neg_ff[k-1];
            pd_ovf_ff[k] <= pd_ovf_ff[k-1];
            pd_a_ff[k]   <= pd_a_ff[k-1];
         end
      end
   end

   // ---------------- quotient saturation
   logic [32:0]        pmag;
   logic signed [33:0] psv;
   logic signed [31:0] p_in, p_ff, p2_ff, p3_ff;

   assign pmag = pd_a_ff[PQ] ? {1'b0, pd_q_ff[PQ]} : {pd_q_ff[PQ], 1'b0};
   assign psv  = pd_neg_ff[PQ] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});

   always_comb begin
      if (car_ff[P_F1-1].pz) begin
         p_in = '0;
      end else if (pd_ovf_ff[PQ]) begin
         p_in = pd_neg_ff[PQ] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (psv > 34'sh0_7FFF_FFFF) begin
         p_in = 32'sh7FFF_FFFF;
      end else if (psv < -34'sh0_8000_0000) begin
         p_in = 32'sh8000_0000;
      end else begin
         p_in = 32'(psv);
      end
   end

   // ---------------- final correction
   logic signed [23:0] ps;
   logic signed [47:0] sq2_ff;
   logic signed [45:0] mp_ff;
   logic signed [60:0] k1_ff;
   logic signed [29:0] x2f_ff;

   assign ps = 24'(p_ff >>> 8);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         sq2_ff <= 48'(ps) * 48'(ps);
         mp_ff  <= 46'(p_ff) * 46'(CORR_LIN);
         p2_ff  <= p_ff;
         k1_ff  <= 61'(sq2_ff) * 61'(CORR_SQ);
         x2f_ff <= 30'(mp_ff >>> 16);
         p3_ff  <= p2_ff;
      end
   end

   logic signed [45:0] csum;
   logic signed [46:0] pfin;
   logic [19:0]        press_in;

   assign csum     = 46'(k1_ff >>> 16) + 46'(x2f_ff) + 46'(CORR_OFS);
   assign pfin     = 47'(p3_ff) + 47'(csum >>> 4);
   assign press_in = pfin[46]                   ? '0 :
                     (pfin > 47'sd1048575)      ? 20'hFFFFF : 20'(pfin);

   logic signed [15:0] rsp_temp_ff;
   logic [19:0]        rsp_press_ff;
   logic               rsp_err_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_temp_ff  <= car_ff[P_F3].t;
         rsp_press_ff <= press_in;
         rsp_err_ff   <= car_ff[P_F3].err | car_ff[P_F3].pz;
      end
   end

   assign rsp_tdata = {4'b0, rsp_press_ff, rsp_temp_ff};
   assign rsp_tuser = rsp_err_ff;

endmodule

`default_nettype wire

### verif/barometric_sensor_compensation_tb.sv
`timescale 1ns / 1ps

module barometric_sensor_compensation_tb;
   import bsc_pkg::*;

   localparam int LATENCY   = 73;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic [15:0] temp_tenths;
      logic [19:0] press_pa;
      logic        div_error;
   } reading_type;

   typedef struct {
      logic [15:0] raw_temp;
      logic [18:0] raw_press;
      bit          typed;
      reading_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_TEMP_COEFFS;
   logic [63:0] csr_wdata = '0;

   barometric_sensor_compensation uut (.*);

   // calibration copy used by the predictor
   logic [63:0] cal_temp, cal_press_a;
   logic [31:0] cal_press_b;
   logic [1:0]  cal_oss;

   reading_type pending_readings[$];
   int  n_errors = 0;
   int  n_readings = 0;
   int  n_div_err = 0;
   int  cycle = 0;
   bit  rsp_free = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("timeout with %0d readings pending", pending_readings.size());
         $display("[barometric_sensor_compensation] ERROR");
         $finish;
      end
   end

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;   // arithmetic shift on signed is a floor divide
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic reading_type compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
      longint ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
      longint ut, up, x1, x2, x3, b3, b4, b5, b6, b7, bsq, p, t, dv;
      int oss;
      reading_type r;
      ac5 = longint'(cal_temp[63:48]);
      ac6 = longint'(cal_temp[47:32]);
      mc  = longint'($signed(cal_temp[31:16]));
      md  = longint'($signed(cal_temp[15:0]));
      ac1 = longint'($signed(cal_press_a[63:48]));
      ac2 = longint'($signed(cal_press_a[47:32]));
      ac3 = longint'($signed(cal_press_a[31:16]));
      ac4 = longint'(cal_press_a[15:0]);
      b1  = longint'($signed(cal_press_b[31:16]));
      b2  = longint'($signed(cal_press_b[15:0]));
      oss = cal_oss;
      ut  = longint'(ut_raw);
      up  = longint'(up_raw);
      r.div_error = 1'b0;

      x1 = floor_shr((ut - ac6) * ac5, 15);
      dv = x1 + md;
      if (dv == 0) begin
         x2 = 0;
         r.div_error = 1'b1;
      end else
         x2 = (mc * 2048) / dv;
      b5 = x1 + x2;
      t = floor_shr(b5 + 8, 4);

      b6  = b5 - B6_OFFSET;
      bsq = floor_shr(b6 * b6, 12);
      x1  = floor_shr(b2 * bsq, 11);
      x2  = floor_shr(ac2 * b6, 11);
      x3  = x1 + x2;
      b3  = floor_shr((ac1 * 4 + x3) * (longint'(1) << oss) + 2, 2);
      x1  = floor_shr(ac3 * b6, 13);
      x2  = floor_shr(b1 * bsq, 16);
      x3  = floor_shr(x1 + x2 + 2, 2);
      b4  = floor_shr(ac4 * (x3 + B4_BIAS), 15);
      b7  = (up - b3) * longint'(PRESS_SCALE >> oss);
      if (b4 == 0) begin
         p = 0;
         r.div_error = 1'b1;
      end else if (b7 >= 0 && b7 < longint'(Q_BOUND))
         p = (b7 * 2) / b4;
      else
         p = (b7 / b4) * 2;
      p  = clip(p, -longint'(Q_BOUND), longint'(Q_BOUND) - 1);
      x1 = floor_shr(p, 8) * floor_shr(p, 8);
      x1 = floor_shr(x1 * CORR_SQ, 16);
      x2 = floor_shr(CORR_LIN * p, 16);
      p  = p + floor_shr(x1 + x2 + CORR_OFS, 4);

      r.temp_tenths = 16'(clip(t, -32768, 32767));
      r.press_pa    = 20'(clip(p, 0, 1048575));
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s at reading %0d: got %0d want %0d", what, n_readings, got, want);
      n_errors++;
   endtask

   // result side: random stalls, checking against the oldest prediction
   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_readings.size() == 0)
               report_mismatch("unexpected item", 1, 0);
            else begin
               want = pending_readings.pop_front();
               if (rsp_tdata[15:0] != want.temp_tenths)
                  report_mismatch("temp_tenths", $signed(rsp_tdata[15:0]),
                                  $signed(want.temp_tenths));
               if (rsp_tdata[35:16] != want.press_pa)
                  report_mismatch("press_pa", rsp_tdata[35:16], want.press_pa);
               if (rsp_tdata[39:36] != 4'd0)
                  report_mismatch("pad bits", rsp_tdata[39:36], 0);
               if (rsp_tuser != want.div_error)
                  report_mismatch("div_error", rsp_tuser, want.div_error);
               if (want.div_error)
                  n_div_err++;
            end
            n_readings++;
         end
         rsp_tready <= rsp_free || ($urandom_range(99) >= 21);
      end
   end

   task automatic write_csr(csr_index_type idx, logic [63:0] val);
      req_tvalid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TEMP_COEFFS:  cal_temp    = val;
         CSR_PRESS_A:      cal_press_a = val;
         CSR_PRESS_B:      cal_press_b = val[31:0];
         CSR_OVERSAMPLING: cal_oss     = val[1:0];
         default: ;
      endcase
   endtask

   // valid stays high after an accept so items can follow back to back
   task automatic send_reading(logic [15:0] ut, logic [18:0] up, bit gaps);
      while (gaps && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, up, ut};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_readings.push_back(compensate(ut, up));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // typical datasheet calibration set
   task automatic load_typical(logic [1:0] oss);
      write_csr(CSR_TEMP_COEFFS, {16'd4743, 16'd23153, 16'hD4BD, 16'd2868});
      write_csr(CSR_PRESS_A, {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741});
      write_csr(CSR_PRESS_B, {16'd6190, 16'd4});
      write_csr(CSR_OVERSAMPLING, 64'(oss));
   endtask

   task automatic load_random;
      write_csr(CSR_TEMP_COEFFS, {$urandom, $urandom});
      write_csr(CSR_PRESS_A, {$urandom, $urandom});
      write_csr(CSR_PRESS_B, {$urandom, $urandom});
      write_csr(CSR_OVERSAMPLING, 64'($urandom_range(3)));
   endtask

   stim_row_type table_rows[$];

   task automatic add_row(logic [15:0] ut, logic [18:0] up, bit typed, reading_type want);
      stim_row_type row;
      row.raw_temp = ut; row.raw_press = up; row.typed = typed; row.want = want;
      table_rows.push_back(row);
   endtask

   initial begin
      reading_type dummy;
      cal_temp = '0; cal_press_a = '0; cal_press_b = '0; cal_oss = '0;
      dummy = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero registers: both divisors are zero, pressure falls back to 236
      add_row(16'd0, 19'd0, 1'b1, '{16'd0, 20'd236, 1'b1});
      add_row(16'hFFFF, 19'h7FFFF, 1'b1, '{16'd0, 20'd236, 1'b1});
      foreach (table_rows[i]) begin
         send_reading(table_rows[i].raw_temp, table_rows[i].raw_press, 1'b0);
         if (table_rows[i].typed && compensate(table_rows[i].raw_temp,
             table_rows[i].raw_press) != table_rows[i].want)
            report_mismatch("table row", i, -1);
      end
      drain();

      // datasheet example and extremes under each oversampling setting
      table_rows.delete();
      add_row(16'd27898, 19'd23843, 1'b0, dummy);
      add_row(16'd0, 19'd0, 1'b0, dummy);
      add_row(16'hFFFF, 19'h7FFFF, 1'b0, dummy);
      add_row(16'd0, 19'h7FFFF, 1'b0, dummy);
      add_row(16'hFFFF, 19'd0, 1'b0, dummy);
      for (int o = 0; o < 4; o++) begin
         load_typical(2'(o));
         foreach (table_rows[i])
            send_reading(table_rows[i].raw_temp, table_rows[i].raw_press, 1'b1);
         drain();
      end

      // extreme calibration: all ones, then zero temperature divisor only
      write_csr(CSR_TEMP_COEFFS, '1);
      write_csr(CSR_PRESS_A, '1);
      write_csr(CSR_PRESS_B, '1);
      write_csr(CSR_OVERSAMPLING, 64'd3);
      send_reading(16'hFFFF, 19'h7FFFF, 1'b0);
      send_reading(16'd0, 19'd0, 1'b0);
      drain();
      load_typical(2'd0);
      write_csr(CSR_TEMP_COEFFS, {16'd0, 16'd0, 16'h8000, 16'd0});
      send_reading(16'd1234, 19'd40000, 1'b0);
      drain();
      write_csr(CSR_PRESS_A, 64'h8000_7FFF_8000_FFFF);
      send_reading(16'd1234, 19'd40000, 1'b0);
      drain();

      // random phases: mostly typical calibration, some fully random sets
      for (int ph = 0; ph < 16; ph++) begin
         if (ph % 3 == 2) load_random();
         else load_typical(2'($urandom_range(3)));
         rsp_free = (ph == 5);
         for (int k = 0; k < 125; k++) begin
            if (ph % 3 != 2 && $urandom_range(3) != 0)
               send_reading(16'($urandom_range(33000, 22000)),
                            19'($urandom_range(120000, 15000)), ph != 5);
            else
               send_reading(16'($urandom), 19'($urandom), ph != 5);
            // hold off until the pipe empties
            if (k == 60 && ph == 7) begin
               req_tvalid <= 1'b0;
               while (pending_readings.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
      rsp_free = 1'b0;

      drain();
      $display("covered %0d readings over 16 random calibration phases, %0d with div_error",
               n_readings, n_div_err);
      if (n_errors == 0)
         $display("[barometric_sensor_compensation] OK");
      else
         $display("[barometric_sensor_compensation] ERROR");
      $finish;
   end

endmodule
